// ----- rtl/websocket_frame_deframer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shorthand for the concurrent checks on the deframer ports.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared constants and the result record of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;
  localparam logic [3:0] OP_NONE  = 4'h0;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CLOSED    = 2'd1;
  localparam logic [1:0] ST_BAD_CTRL  = 2'd2;
  localparam logic [1:0] ST_BAD_DATA  = 2'd3;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic [3:0] frame_op;
    logic       is_control;
    logic       frame_end;
    logic       message_end;
    logic [3:0] reply_op;
    logic [1:0] status;
  } res_t;

  // handshake view of the result buffer towards the parser
  typedef struct packed {
    logic push;
    logic space;
  } buf_ctl_t;

endpackage

// ----- rtl/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Received-byte WebSocket deframer: header parse, unmasking, control replies.
// ----------------------------------------------------------------------------
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------------
//  in_     | in  | one received byte
//  out_    | out | one payload byte / empty frame end / status, with tags
//
//  While in_tready is high every byte is taken in the cycle it is presented;
//  the parser updates its state and writes any result into the output
//  register or skid entry at the same edge, so the sustained rate is one
//  byte per clock.
//  A skid entry behind the output register lets one more byte in while a
//  result is stalled; in_tready drops only when both entries are full.
//  rst_n is synchronous; after reset the parser waits for a first header byte.
//  A close frame or a protocol error halts parsing: later bytes are still
//  taken but give no result until reset.
//
module websocket_frame_deframer_unit
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [11:8] frame_op,
                                  // [12] message_end, [15:13] zero
  output logic [7:0]  out_tuser,  // [0] has_byte, [1] is_control,
                                  // [5:2] reply_op, [7:6] status
  output logic        out_tlast   // frame_end
);

  logic     byte_take;
  logic     res_valid;
  res_t     res;
  res_t     out_res;
  buf_ctl_t buf_ctl;

  // ready comes from the skid flag only, never from out_tready
  assign in_tready = buf_ctl.space;
  assign byte_take = in_tvalid && in_tready;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .ctl       (buf_ctl),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  // pack the result record onto the stream ports
  assign out_tdata = {3'b000, out_res.message_end, out_res.frame_op, out_res.data_byte};
  assign out_tuser = {out_res.status, out_res.reply_op, out_res.is_control,
                      out_res.has_byte};
  assign out_tlast = out_res.frame_end;

endmodule

// ----- rtl/wsfd_parser.sv -----
// ----------------------------------------------------------------------------
// wsfd_parser
// Header/length/mask state machine; turns one byte into at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_MASK, PH_PAY, PH_HALT
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [2:0]  ext_left_r,  ext_left_nxt;
  logic        fin_flag_r,  fin_flag_nxt;
  logic [3:0]  cur_op_r,    cur_op_nxt;
  logic        masked_r,    masked_nxt;
  logic [63:0] remaining_r, remaining_nxt;
  logic [31:0] mask_word_r, mask_word_nxt;
  logic [1:0]  mask_pos_r,  mask_pos_nxt;
  logic [3:0]  msg_op_r,    msg_op_nxt;

  logic        ctrl;
  logic [3:0]  reply;
  assign ctrl  = cur_op_r[3];
  assign reply = (cur_op_r == OP_PING)  ? OP_PONG :
                 (cur_op_r == OP_CLOSE) ? OP_CLOSE : OP_NONE;

  always_comb begin
    logic [3:0]  op;
    logic        sp_req;
    logic [63:0] sp_rem;
    logic        fin_req;
    logic        fin_has;
    logic [7:0]  fin_b;
    logic [7:0]  key;
    logic [7:0]  d;
    logic [63:0] ext_rem;

    phase_nxt     = phase_r;
    ext_left_nxt  = ext_left_r;
    fin_flag_nxt  = fin_flag_r;
    cur_op_nxt    = cur_op_r;
    masked_nxt    = masked_r;
    remaining_nxt = remaining_r;
    mask_word_nxt = mask_word_r;
    mask_pos_nxt  = mask_pos_r;
    msg_op_nxt    = msg_op_r;
    res_valid     = 1'b0;
    res           = '0;
    op            = rx_byte[3:0];
    sp_req        = 1'b0;
    sp_rem        = remaining_r;
    fin_req       = 1'b0;
    fin_has       = 1'b0;
    fin_b         = 8'h00;
    key           = 8'h00;
    d             = 8'h00;
    ext_rem       = {remaining_r[55:0], rx_byte};

    if (byte_take) begin
      case (phase_r)
        PH_HDR0: begin
          fin_flag_nxt = rx_byte[7];
          cur_op_nxt   = op;
          phase_nxt    = PH_HDR1;
          if (op[3]) begin
            if (!(op == OP_CLOSE || op == OP_PING || op == OP_PONG)) begin
              res_valid        = 1'b1;
              res.frame_op     = op;
              res.is_control   = 1'b1;
              res.status       = ST_BAD_CTRL;
              phase_nxt        = PH_HALT;
            end
          end else if ((msg_op_r == OP_NONE) == (op == OP_CONT)) begin
            res_valid      = 1'b1;
            res.frame_op   = op;
            res.status     = ST_BAD_DATA;
            phase_nxt      = PH_HALT;
          end else if (op != OP_CONT) begin
            msg_op_nxt = op;
          end
        end
        PH_HDR1: begin
          masked_nxt    = rx_byte[7];
          mask_word_nxt = '0;
          mask_pos_nxt  = '0;
          remaining_nxt = '0;
          if (rx_byte[6:0] == LEN_EXT16) begin
            ext_left_nxt = 3'd1;
            phase_nxt    = PH_EXT;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            ext_left_nxt = 3'd7;
            phase_nxt    = PH_EXT;
          end else begin
            remaining_nxt = {57'd0, rx_byte[6:0]};
            if (rx_byte[7]) begin
              phase_nxt = PH_MASK;
            end else begin
              sp_req = 1'b1;
              sp_rem = {57'd0, rx_byte[6:0]};
            end
          end
        end
        PH_EXT: begin
          remaining_nxt = ext_rem;
          if (ext_left_r == 3'd0) begin
            if (masked_r) begin
              phase_nxt    = PH_MASK;
              mask_pos_nxt = '0;
            end else begin
              sp_req = 1'b1;
              sp_rem = ext_rem;
            end
          end else begin
            ext_left_nxt = ext_left_r - 3'd1;
          end
        end
        PH_MASK: begin
          case (mask_pos_r)
            2'd0:    mask_word_nxt[31:24] = rx_byte;
            2'd1:    mask_word_nxt[23:16] = rx_byte;
            2'd2:    mask_word_nxt[15:8]  = rx_byte;
            default: mask_word_nxt[7:0]   = rx_byte;
          endcase
          mask_pos_nxt = mask_pos_r + 2'd1;
          if (mask_pos_r == 2'd3) begin
            sp_req = 1'b1;
          end
        end
        PH_PAY: begin
          if (masked_r) begin
            case (mask_pos_r)
              2'd0:    key = mask_word_r[31:24];
              2'd1:    key = mask_word_r[23:16];
              2'd2:    key = mask_word_r[15:8];
              default: key = mask_word_r[7:0];
            endcase
          end
          d             = rx_byte ^ key;
          mask_pos_nxt  = mask_pos_r + 2'd1;
          remaining_nxt = remaining_r - 64'd1;
          if (remaining_r == 64'd1) begin
            fin_req = 1'b1;
            fin_has = 1'b1;
            fin_b   = d;
          end else if (cur_op_r != OP_PONG) begin
            res_valid      = 1'b1;
            res.has_byte   = 1'b1;
            res.data_byte  = d;
            res.frame_op   = ctrl ? cur_op_r : msg_op_r;
            res.is_control = ctrl;
            res.reply_op   = reply;
            res.status     = ST_OK;
          end
        end
        default: begin
          // halted: bytes are swallowed until reset
        end
      endcase

      // payload start: an empty frame ends straight away
      if (sp_req) begin
        if (sp_rem == 64'd0) begin
          fin_req = 1'b1;
        end else begin
          phase_nxt = PH_PAY;
        end
      end

      if (fin_req) begin
        phase_nxt = PH_HDR0;
        if (cur_op_r != OP_PONG) begin
          res_valid       = 1'b1;
          res.has_byte    = fin_has;
          res.data_byte   = fin_b;
          res.frame_op    = ctrl ? cur_op_r : msg_op_r;
          res.is_control  = ctrl;
          res.frame_end   = 1'b1;
          res.message_end = !ctrl && fin_flag_r;
          res.reply_op    = reply;
          res.status      = ST_OK;
          if (cur_op_r == OP_CLOSE) begin
            res.status = ST_CLOSED;
            phase_nxt  = PH_HALT;
          end
          if (!ctrl && fin_flag_r) begin
            msg_op_nxt = OP_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      ext_left_r  <= '0;
      fin_flag_r  <= 1'b0;
      cur_op_r    <= '0;
      masked_r    <= 1'b0;
      remaining_r <= '0;
      mask_word_r <= '0;
      mask_pos_r  <= '0;
      msg_op_r    <= OP_NONE;
    end else begin
      phase_r     <= phase_nxt;
      ext_left_r  <= ext_left_nxt;
      fin_flag_r  <= fin_flag_nxt;
      cur_op_r    <= cur_op_nxt;
      masked_r    <= masked_nxt;
      remaining_r <= remaining_nxt;
      mask_word_r <= mask_word_nxt;
      mask_pos_r  <= mask_pos_nxt;
      msg_op_r    <= msg_op_nxt;
    end
  end

endmodule

// ----- rtl/wsfd_obuf.sv -----
// ----------------------------------------------------------------------------
// wsfd_obuf
// Output register with a skid entry; ready towards the parser is registered.
// ----------------------------------------------------------------------------
module wsfd_obuf
  import wsfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  res_t     push_res,
  output buf_ctl_t ctl,
  input  logic     out_ready,
  output logic     out_valid,
  output res_t     out_res
);

  logic out_v_r, out_v_nxt;
  logic sk_v_r,  sk_v_nxt;
  res_t out_d_r, sk_d_r;
  logic drain;

  assign drain     = out_v_r && out_ready;
  assign out_valid = out_v_r;
  assign out_res   = out_d_r;
  assign ctl       = {push, !sk_v_r};

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    if (sk_v_r) begin
      if (drain) begin
        sk_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !drain) begin
        sk_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b1;
      end
    end else if (drain) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (drain) begin
        out_d_r <= sk_d_r;
      end
    end else if (push) begin
      if (out_v_r && !drain) begin
        sk_d_r <= push_res;
      end else begin
        out_d_r <= push_res;
      end
    end
  end

endmodule

// ----- rtl/wsfd_chk.sv -----
// ----------------------------------------------------------------------------
// wsfd_chk
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_unit_assert.svh"

module wsfd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [7:0]  out_tuser,
  input logic        out_tlast
);

  `WSFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")
  `WSFD_ASSERT_NOW(a_empty_zero, out_tvalid && !out_tuser[0], out_tdata[7:0] == 8'h00, "data byte set without has_byte")
  `WSFD_ASSERT_NOW(a_msg_end, out_tvalid && out_tdata[12], out_tlast && !out_tuser[1], "message end outside a data frame end")
  `WSFD_ASSERT_NOW(a_reply_ctrl, out_tvalid && (out_tuser[5:2] != 4'h0), out_tuser[1], "reply on a data frame")
  `WSFD_ASSERT_NEXT(a_halt_quiet, out_tvalid && out_tready && (out_tuser[7:6] != 2'd0), !out_tvalid, "result after halt")

endmodule

bind websocket_frame_deframer_unit wsfd_chk u_wsfd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - WebSocket frame deframer testbench
// Streams whole frames through the deframer and checks every result
// transfer against an in-bench model of the header parser and unmasker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wsfd_pkg::*;

  // data opcodes not named in the package
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;

  // length encodings used when building a header
  localparam int unsigned LF_SHORT = 0;
  localparam int unsigned LF_EXT16 = 1;
  localparam int unsigned LF_EXT64 = 2;

  // random part length in bytes, receiver hold-off
  localparam int unsigned RAND_BYTES  = 1700;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 200;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_MASK, PH_PAY, PH_HALT
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [7:0] data_byte, [11:8] frame_op, [12] message_end
  logic [7:0]  out_tuser;   // [0] has_byte, [1] is_control, [5:2] reply_op,
                            // [7:6] status
  logic        out_tlast;   // frame_end

  websocket_frame_deframer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  logic [7:0] rx_bytes[$];     // bytes still to be sent, front is on the bus
  res_t       deframed_q[$];   // predicted results not yet seen at the output
  int         fails = 0;
  int         results_seen = 0;
  int         cyc = 0;
  logic       in_taken = 1'b0; // input transfer at the last rising edge
  logic       calm;            // window with no random idling on either side
  bit         gen_open = 1'b0; // generator's view: data message in progress

  assign calm = (cyc >= 800) && (cyc < 1300);

  // --------------------------------------------------------------------------
  // Deframer model: its own copy of the parser state
  // --------------------------------------------------------------------------
  parse_phase_t ph = PH_HDR0;
  logic [2:0]   ext_cnt = '0;   // extended length bytes still due, minus one
  logic         fin = 1'b0;
  logic [3:0]   cur = OP_NONE;  // opcode of the frame being parsed
  logic         msk = 1'b0;
  logic [63:0]  rem = '0;       // payload bytes left
  logic [31:0]  key = '0;       // first key byte in [31:24]
  logic [1:0]   kpos = '0;
  logic [3:0]   msg = OP_NONE;  // opcode of the open message, none if zero

  // tag a result with the current frame's context
  task automatic queue_result(input logic has, input logic [7:0] d, input logic fend,
                              input logic [1:0] st);
    res_t r;
    logic ctrl;
    ctrl          = cur[3];
    r.has_byte    = has;
    r.data_byte   = has ? d : 8'h00;
    r.frame_op    = ctrl ? cur : msg;
    r.is_control  = ctrl;
    r.frame_end   = fend;
    r.message_end = !ctrl && fin && fend;
    r.reply_op    = (ctrl && cur == OP_PING)  ? OP_PONG :
                    (ctrl && cur == OP_CLOSE) ? OP_CLOSE : OP_NONE;
    r.status      = st;
    deframed_q.push_back(r);
  endtask

  // bad opcode: one status result, then nothing until reset
  task automatic protocol_error(input logic [3:0] op, input logic [1:0] st);
    res_t r;
    r             = '0;
    r.frame_op    = op;
    r.is_control  = op[3];
    r.status      = st;
    deframed_q.push_back(r);
    ph = PH_HALT;
  endtask

  // last byte of a frame, or an empty frame at header end
  task automatic close_frame(input logic has, input logic [7:0] d);
    logic [1:0] st;
    st = ST_OK;
    ph = PH_HDR0;
    if (cur == OP_PONG) return;   // pongs are swallowed whole
    if (cur == OP_CLOSE) begin
      st = ST_CLOSED;
      ph = PH_HALT;
    end
    queue_result(has, d, 1'b1, st);
    if (!cur[3] && fin) msg = OP_NONE;
  endtask

  task automatic begin_payload();
    if (rem == 0) close_frame(1'b0, 8'h00);
    else ph = PH_PAY;
  endtask

  task automatic after_length();
    if (msk) begin
      ph   = PH_MASK;
      kpos = '0;
    end else begin
      begin_payload();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] k;
    case (ph)
      PH_HDR0: begin
        fin = b[7];
        cur = b[3:0];
        if (cur[3]) begin
          if (cur != OP_CLOSE && cur != OP_PING && cur != OP_PONG) begin
            protocol_error(cur, ST_BAD_CTRL);
            return;
          end
        end else begin
          // continuation only inside a message, new opcode only outside one
          if ((msg == OP_NONE) == (cur == OP_CONT)) begin
            protocol_error(cur, ST_BAD_DATA);
            return;
          end
          if (cur != OP_CONT) msg = cur;
        end
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        msk  = b[7];
        key  = '0;
        kpos = '0;
        rem  = '0;
        if (b[6:0] == LEN_EXT16) begin
          ext_cnt = 3'd1;
          ph      = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_cnt = 3'd7;
          ph      = PH_EXT;
        end else begin
          rem = 64'(b[6:0]);
          after_length();
        end
      end
      PH_EXT: begin
        rem = {rem[55:0], b};
        if (ext_cnt == 0) after_length();
        else ext_cnt = ext_cnt - 3'd1;
      end
      PH_MASK: begin
        key[(3 - kpos) * 8 +: 8] = b;
        if (kpos == 2'd3) begin
          kpos = '0;
          begin_payload();
        end else begin
          kpos = kpos + 2'd1;
        end
      end
      PH_PAY: begin
        k    = msk ? key[(3 - kpos) * 8 +: 8] : 8'h00;
        kpos = kpos + 2'd1;
        rem  = rem - 64'd1;
        if (rem == 0) close_frame(1'b1, b ^ k);
        else if (cur != OP_PONG) queue_result(1'b1, b ^ k, 1'b0, ST_OK);
      end
      default: ;  // halted: bytes are dropped
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Frame builder: appends one complete frame to the send queue
  // --------------------------------------------------------------------------
  task automatic add_frame(input bit f, input logic [3:0] op, input bit mask_on,
                           input int unsigned len, input int unsigned lform);
    logic [63:0] l64;
    l64 = 64'(len);
    // reserved bits are not checked, so they carry noise
    rx_bytes.push_back({f, 3'($urandom), op});
    case (lform)
      LF_SHORT: rx_bytes.push_back({mask_on, l64[6:0]});
      LF_EXT16: begin
        rx_bytes.push_back({mask_on, LEN_EXT16});
        rx_bytes.push_back(l64[15:8]);
        rx_bytes.push_back(l64[7:0]);
      end
      default: begin
        rx_bytes.push_back({mask_on, LEN_EXT64});
        for (int i = 7; i >= 0; i--) rx_bytes.push_back(l64[8 * i +: 8]);
      end
    endcase
    if (mask_on) repeat (4) rx_bytes.push_back(8'($urandom));
    repeat (len) rx_bytes.push_back(8'($urandom));
    if (!op[3]) begin
      if (op != OP_CONT) gen_open = 1'b1;
      if (f) gen_open = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the front of rx_bytes, changes only on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_proc
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    if (rst_n) begin
      if (in_taken) void'(rx_bytes.pop_front());
      if (in_tvalid && !in_taken) begin
        // offer still pending: hold valid and data
      end else if (rx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
        nxt_valid = 1'b1;
        nxt_data  = rx_bytes[0];
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off once results flow,
  // so the output register and skid entry fill and in_tready drops
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: model update on each input transfer, check on each result
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : monitor_proc
    res_t want;
    cyc      <= cyc + 1;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      // model first: a result can never arrive in the cycle of its byte
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (deframed_q.size() == 0) begin
          $error("result transfer with nothing predicted: tdata %h tuser %h tlast %b",
                 out_tdata, out_tuser, out_tlast);
          fails++;
        end else begin
          want = deframed_q.pop_front();
          check_field("has_byte",    8'(want.has_byte),    8'(out_tuser[0]));
          check_field("data_byte",   want.data_byte,       out_tdata[7:0]);
          check_field("frame_op",    8'(want.frame_op),    8'(out_tdata[11:8]));
          check_field("is_control",  8'(want.is_control),  8'(out_tuser[1]));
          check_field("frame_end",   8'(want.frame_end),   8'(out_tlast));
          check_field("message_end", 8'(want.message_end), 8'(out_tdata[12]));
          check_field("reply_op",    8'(want.reply_op),    8'(out_tuser[5:2]));
          check_field("status",      8'(want.status),      8'(out_tuser[7:6]));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    int unsigned sel;
    int unsigned len;
    int unsigned lsel;
    int unsigned lform;
    logic [3:0]  op;

    // Directed: empty frame, masked start of a fragmented message with a ping
    // and a pong in the middle, continuation via 16-bit length, a one-byte
    // message via 64-bit length, and an empty ping.
    add_frame(1'b1, OP_TEXT,   1'b0, 0, LF_SHORT);
    add_frame(1'b0, OP_BINARY, 1'b1, 3, LF_SHORT);
    add_frame(1'b1, OP_PING,   1'b1, 1, LF_SHORT);
    add_frame(1'b1, OP_PONG,   1'b0, 2, LF_SHORT);
    add_frame(1'b1, OP_CONT,   1'b0, 2, LF_EXT16);
    add_frame(1'b1, OP_BINARY, 1'b0, 1, LF_EXT64);
    add_frame(1'b0, OP_PING,   1'b0, 0, LF_EXT64);

    // Random well-formed traffic: mostly short frames, some long ones behind
    // extended lengths, control frames mixed in between fragments.
    while (rx_bytes.size() < RAND_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) len = $urandom_range(0, 20);
      else if (sel < 95) len = $urandom_range(21, 125);
      else len = $urandom_range(126, 400);
      lsel = $urandom_range(0, 9);
      if (len >= 126) lform = (lsel < 8) ? LF_EXT16 : LF_EXT64;
      else lform = (lsel < 7) ? LF_SHORT : (lsel < 9) ? LF_EXT16 : LF_EXT64;
      sel = $urandom_range(0, 99);
      if (sel < 12) op = OP_PING;
      else if (sel < 18) op = OP_PONG;
      else if (gen_open) op = OP_CONT;
      else op = 4'($urandom_range(1, 7));
      add_frame($urandom_range(0, 3) != 0, op, 1'($urandom), len, lform);
    end

    // Every halting case ends the stream for good, so the seed picks one:
    // peer close, unknown control opcode, or a data opcode out of message order.
    case ($urandom_range(0, 2))
      0: add_frame(1'($urandom), OP_CLOSE, 1'($urandom), $urandom_range(0, 6), LF_SHORT);
      1: rx_bytes.push_back({1'($urandom), 3'($urandom), 4'($urandom_range(11, 15))});
      default: rx_bytes.push_back({1'($urandom), 3'($urandom),
                                   gen_open ? 4'($urandom_range(1, 7)) : OP_CONT});
    endcase
    // trailing bytes must be swallowed silently
    repeat (12) rx_bytes.push_back(8'($urandom));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_bytes.size() != 0 || deframed_q.size() != 0) @(posedge clk);
    // allow a margin for stray results
    repeat (20) @(posedge clk);
    if (fails == 0 && deframed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // generous limit on the run time
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
